// ===== src/assert_macros.svh =====
// Assertion macros shared by the multi-shape LFO modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a property on every rising clock edge while out of reset.
`define MSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Checks that a condition never holds on a rising clock edge while out of reset.
`define MSL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define MSL_ASSERT(lbl, clk, rst_n, prop)
`define MSL_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/mslfo_pkg.sv =====
// Types, constants and the sine quarter-wave table of the multi-shape LFO.
package mslfo_pkg;

    localparam int STEP_W     = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int SAMPLE_W   = 16;
    localparam int SAT_W      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 8'd1;

    typedef enum logic [2:0] {
        WAVE_SIN    = 3'd0,
        WAVE_TRI    = 3'd1,
        WAVE_SAW    = 3'd2,
        WAVE_SQR    = 3'd3,
        WAVE_HOLD   = 3'd4,
        WAVE_SMOOTH = 3'd5,
        WAVE_WALK   = 3'd6,
        WAVE_ZERO   = 3'd7
    } t_wave;

    // Snapshot of one tick after the state update, passed to the shaper.
    typedef struct packed {
        logic                       zero;
        logic                       wrap;
        logic signed [SAMPLE_W-1:0] held;
        logic signed [SAMPLE_W-1:0] target;
        logic signed [SAMPLE_W-1:0] walk;
    } t_tick;

    // Sine table geometry: one quadrant of the full table is stored.
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
    localparam int SINE_QTR     = SINE_ENTRIES / 4;
    localparam int SINE_QTR_W   = SINE_IDX_W - 2;
    localparam int MAG_W        = SAMPLE_W - 1;

    // Odd-polynomial coefficients in Q30.
    localparam longint unsigned SC1 = 64'd1686629713;
    localparam longint unsigned SC3 = 64'd693598669;
    localparam longint unsigned SC5 = 64'd85569306;
    localparam longint unsigned SC7 = 64'd5026991;
    localparam longint unsigned SC9 = 64'd172273;

    typedef logic [MAG_W-1:0] t_sine_qtr [SINE_QTR];

    // Magnitude of the sine at quadrant position m (0 .. SINE_QTR), rounded Q1.15.
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned m);
        longint unsigned y;
        longint unsigned y2;
        longint unsigned r;
        longint unsigned s;
        y  = longint'(m) << (30 - SINE_QTR_W);
        y2 = (y * y) >> 30;
        r  = SC9;
        r  = SC7 - ((y2 * r) >> 30);
        r  = SC5 - ((y2 * r) >> 30);
        r  = SC3 - ((y2 * r) >> 30);
        r  = SC1 - ((y2 * r) >> 30);
        s  = (y * r) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[MAG_W-1:0];
    endfunction

    function automatic t_sine_qtr build_sine_qtr();
        t_sine_qtr tab;
        for (int i = 0; i < SINE_QTR; i++) begin
            tab[i] = sine_mag(i);
        end
        return tab;
    endfunction

    localparam t_sine_qtr       SINE_QTR_TAB = build_sine_qtr();
    localparam logic [MAG_W-1:0] SINE_PEAK   = sine_mag(SINE_QTR);

    // Saturates a wide signed value to the Q1.15 range.
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [SAMPLE_W-1:0] res;
        if (v > 40'sd32767) begin
            res = 16'sd32767;
        end else if (v < -40'sd32768) begin
            res = -16'sd32768;
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/mslfo_cfg.sv =====
// Configuration registers: phase step and waveform selector.
module mslfo_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mslfo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mslfo_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [mslfo_pkg::STEP_W-1:0]        o_phase_step,
    output mslfo_pkg::t_wave                    o_wave_select
);

    logic [mslfo_pkg::STEP_W-1:0] r_phase_step;
    logic [mslfo_pkg::STEP_W-1:0] n_phase_step;
    mslfo_pkg::t_wave             r_wave_select;
    mslfo_pkg::t_wave             n_wave_select;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_phase_step  = r_phase_step;
        n_wave_select = r_wave_select;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                mslfo_pkg::CFG_PHASE_STEP: begin
                    n_phase_step = i_cfg_data[mslfo_pkg::STEP_W-1:0];
                end
                mslfo_pkg::CFG_WAVE_SELECT: begin
                    n_wave_select = mslfo_pkg::t_wave'(i_cfg_data[2:0]);
                end
                default: begin
                    // Writes to unknown registers are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_wave_select <= mslfo_pkg::WAVE_SIN;
        end else begin
            r_phase_step  <= n_phase_step;
            r_wave_select <= n_wave_select;
        end
    end

    assign o_phase_step  = r_phase_step;
    assign o_wave_select = r_wave_select;

endmodule

// ===== src/mslfo_state.sv =====
// Phase accumulator, random state update and the first pipeline register.
`include "assert_macros.svh"
module mslfo_state #(
    parameter int PHASE_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_accept,
    input  logic                                      i_drain,
    input  logic [mslfo_pkg::STEP_W-1:0]              i_phase_step,
    input  logic signed [mslfo_pkg::SAMPLE_W-1:0]     i_draw_target,
    input  logic signed [mslfo_pkg::SAMPLE_W-1:0]     i_draw_walk,
    output logic                                      o_s1_valid,
    output logic [PHASE_BITS-1:0]                     o_s1_phase,
    output mslfo_pkg::t_tick                          o_s1_tick
);

    localparam int SW = mslfo_pkg::SAT_W;

    logic [PHASE_BITS-1:0]                  r_phase;
    logic [PHASE_BITS-1:0]                  n_phase;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  r_held;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  n_held;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  r_target;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  n_target;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  r_walk;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  n_walk;
    logic                                   r_s1_valid;
    logic                                   n_s1_valid;
    logic [PHASE_BITS-1:0]                  r_s1_phase;
    logic [PHASE_BITS-1:0]                  n_s1_phase;
    mslfo_pkg::t_tick                       r_s1_tick;
    mslfo_pkg::t_tick                       n_s1_tick;

    logic [PHASE_BITS-1:0]                  step_mod;
    logic [PHASE_BITS:0]                    phase_sum;
    logic                                   step_zero;
    logic                                   wrap_now;
    logic signed [30:0]                     walk_prod;
    logic signed [30:0]                     walk_round;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  walk_delta;
    logic signed [mslfo_pkg::SAMPLE_W:0]    walk_sum;

    // The step is reduced modulo one cycle, so at most one wrap per tick.
    if (PHASE_BITS >= mslfo_pkg::STEP_W) begin : g_step_wide
        assign step_mod = PHASE_BITS'(i_phase_step);
    end else begin : g_step_narrow
        assign step_mod = i_phase_step[PHASE_BITS-1:0];
    end

    assign phase_sum = {1'b0, r_phase} + {1'b0, step_mod};
    assign step_zero = (i_phase_step == '0);
    assign wrap_now  = !step_zero && phase_sum[PHASE_BITS];

    // Walk increment: round(draw * 0.2) with 6554/32768, floor after the bias.
    assign walk_prod  = 31'(i_draw_walk) * 31'sd6554;
    assign walk_round = walk_prod + 31'sd16384;
    assign walk_delta = walk_round[30:15];
    assign walk_sum   = {r_walk[mslfo_pkg::SAMPLE_W-1], r_walk}
                      + {walk_delta[mslfo_pkg::SAMPLE_W-1], walk_delta};

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_target = r_target;
        n_walk   = r_walk;
        if (i_accept && !step_zero) begin
            n_phase = phase_sum[PHASE_BITS-1:0];
            if (wrap_now) begin
                n_held   = r_target;
                n_target = i_draw_target;
                n_walk   = mslfo_pkg::sat16(SW'(walk_sum));
            end
        end

        n_s1_valid = r_s1_valid;
        if (i_accept) begin
            n_s1_valid = 1'b1;
        end else if (i_drain) begin
            n_s1_valid = 1'b0;
        end

        n_s1_phase = r_s1_phase;
        n_s1_tick  = r_s1_tick;
        if (i_accept) begin
            n_s1_phase       = n_phase;
            n_s1_tick.zero   = step_zero;
            n_s1_tick.wrap   = wrap_now;
            n_s1_tick.held   = n_held;
            n_s1_tick.target = n_target;
            n_s1_tick.walk   = n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_held     <= '0;
            r_target   <= '0;
            r_walk     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_target   <= n_target;
            r_walk     <= n_walk;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_phase <= n_s1_phase;
        r_s1_tick  <= n_s1_tick;
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_phase = r_s1_phase;
    assign o_s1_tick  = r_s1_tick;

    `MSL_ASSERT(a_zero_step_freezes_phase, i_clk, i_rst_n, (i_accept && step_zero) |=> $stable(r_phase))
    `MSL_ASSERT(a_walk_moves_only_on_wrap, i_clk, i_rst_n, ($past(i_rst_n) && !$stable(r_walk)) |-> ($past(i_accept) && r_s1_tick.wrap))
    `MSL_ASSERT_NEVER(a_zero_step_never_wraps, i_clk, i_rst_n, r_s1_valid && r_s1_tick.zero && r_s1_tick.wrap)

endmodule

// ===== src/mslfo_shape.sv =====
// Waveform shaper and the result register.
`include "assert_macros.svh"
module mslfo_shape #(
    parameter int PHASE_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_load,
    input  logic                                      i_out_ready,
    input  mslfo_pkg::t_wave                          i_wave_select,
    input  logic [PHASE_BITS-1:0]                     i_phase,
    input  mslfo_pkg::t_tick                          i_tick,
    output logic                                      o_out_valid,
    output logic signed [mslfo_pkg::SAMPLE_W-1:0]     o_lfo_value,
    output logic                                      o_cycle_wrapped
);

    localparam int SW  = mslfo_pkg::SAT_W;
    localparam int PW  = PHASE_BITS + 3;
    localparam int SHL = (PHASE_BITS >= 15) ? 0 : 15 - PHASE_BITS;
    localparam int SHR = (PHASE_BITS >= 15) ? PHASE_BITS - 15 : 0;
    localparam int WQ  = PW + SHL;
    localparam int MW  = PHASE_BITS + 18;
    localparam int IW  = mslfo_pkg::SINE_IDX_W;
    localparam int QW  = mslfo_pkg::SINE_QTR_W;

    localparam logic signed [PW-1:0] ONE_S       = {3'b001, {PHASE_BITS{1'b0}}};
    localparam logic signed [PW-1:0] THREE_ONE_S = {3'b011, {PHASE_BITS{1'b0}}};
    localparam logic [QW:0]          QTR_N       = {1'b1, {QW{1'b0}}};

    logic                                   r_out_valid;
    logic                                   n_out_valid;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  r_lfo_value;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  n_lfo_value;
    logic                                   r_cycle_wrapped;
    logic                                   n_cycle_wrapped;

    logic signed [PW-1:0]                   ph_s;
    logic signed [PW-1:0]                   tri_v;
    logic signed [PW-1:0]                   saw_v;
    logic signed [WQ-1:0]                   tri_w;
    logic signed [WQ-1:0]                   saw_w;
    logic signed [WQ-1:0]                   tri_q;
    logic signed [WQ-1:0]                   saw_q;

    logic [IW-1:0]                          sine_idx;
    logic [1:0]                             quad;
    logic [QW:0]                            qpos;
    logic [mslfo_pkg::MAG_W-1:0]            mag;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  sine_pos;
    logic signed [mslfo_pkg::SAMPLE_W-1:0]  sine_val;

    logic signed [mslfo_pkg::SAMPLE_W:0]    diff;
    logic signed [MW-1:0]                   sm_prod;
    logic signed [mslfo_pkg::SAMPLE_W+1:0]  sm_part;
    logic signed [mslfo_pkg::SAMPLE_W+2:0]  sm_sum;

    // Triangle and saw in Q(PHASE_BITS), then floored into Q1.15.
    assign ph_s  = $signed({3'b000, i_phase});
    assign tri_v = i_phase[PHASE_BITS-1] ? (THREE_ONE_S - (ph_s <<< 2))
                                         : ((ph_s <<< 2) - ONE_S);
    assign saw_v = (ph_s <<< 1) - ONE_S;
    assign tri_w = WQ'(tri_v);
    assign saw_w = WQ'(saw_v);
    assign tri_q = (tri_w <<< SHL) >>> SHR;
    assign saw_q = (saw_w <<< SHL) >>> SHR;

    // Sine from a quarter-wave table, mirrored in odd quadrants and negated
    // in the second half cycle. The quadrant end point is the peak value.
    assign sine_idx = i_phase[PHASE_BITS-1 -: IW];
    assign quad     = sine_idx[IW-1 -: 2];
    assign qpos     = quad[0] ? (QTR_N - {1'b0, sine_idx[QW-1:0]})
                              : {1'b0, sine_idx[QW-1:0]};
    assign mag      = qpos[QW] ? mslfo_pkg::SINE_PEAK
                               : mslfo_pkg::SINE_QTR_TAB[qpos[QW-1:0]];
    assign sine_pos = $signed({1'b0, mag});
    assign sine_val = quad[1] ? -sine_pos : sine_pos;

    // Smooth random: held + floor((target - held) * phase / one).
    assign diff    = {i_tick.target[mslfo_pkg::SAMPLE_W-1], i_tick.target}
                   - {i_tick.held[mslfo_pkg::SAMPLE_W-1], i_tick.held};
    assign sm_prod = MW'(diff) * MW'($signed({1'b0, i_phase}));
    assign sm_part = sm_prod[MW-1:PHASE_BITS];
    assign sm_sum  = (mslfo_pkg::SAMPLE_W+3)'(sm_part)
                   + (mslfo_pkg::SAMPLE_W+3)'(i_tick.held);

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        n_lfo_value     = r_lfo_value;
        n_cycle_wrapped = r_cycle_wrapped;
        if (i_load) begin
            n_cycle_wrapped = i_tick.wrap;
            case (i_wave_select)
                mslfo_pkg::WAVE_SIN:    n_lfo_value = sine_val;
                mslfo_pkg::WAVE_TRI:    n_lfo_value = mslfo_pkg::sat16(SW'(tri_q));
                mslfo_pkg::WAVE_SAW:    n_lfo_value = mslfo_pkg::sat16(SW'(saw_q));
                mslfo_pkg::WAVE_SQR: begin
                    n_lfo_value = i_phase[PHASE_BITS-1] ? -16'sd32768 : 16'sd32767;
                end
                mslfo_pkg::WAVE_HOLD:   n_lfo_value = i_tick.held;
                mslfo_pkg::WAVE_SMOOTH: n_lfo_value = mslfo_pkg::sat16(SW'(sm_sum));
                mslfo_pkg::WAVE_WALK:   n_lfo_value = i_tick.walk;
                default:                n_lfo_value = '0;
            endcase
            if (i_tick.zero) begin
                n_lfo_value = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lfo_value     <= n_lfo_value;
        r_cycle_wrapped <= n_cycle_wrapped;
    end

    assign o_out_valid     = r_out_valid;
    assign o_lfo_value     = r_lfo_value;
    assign o_cycle_wrapped = r_cycle_wrapped;

    `MSL_ASSERT(a_zero_step_gives_zero, i_clk, i_rst_n, (i_load && i_tick.zero) |=> (r_lfo_value == '0 && !r_cycle_wrapped))

endmodule

// ===== src/multi_shape_lfo.sv =====
// Top level of the multi-shape low-frequency oscillator.
//
//  Channel  Direction  Handshake                   Payload
//  in       input      i_in_valid / o_in_ready     i_draw_target, i_draw_walk
//  out      output     o_out_valid / i_out_ready   o_lfo_value, o_cycle_wrapped
//  cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Each item passes two register stages, the first-stage register and the
// result register; one item can be accepted in every cycle while the output
// is not stalled.
// The first stage updates the phase accumulator and the random state, the
// second stage forms the selected waveform into the result register.
// Reset is synchronous and active low; it clears the configuration, the phase
// and the random state, and empties both stages.
// When the output is stalled both stages fill up and then the input stalls;
// a result register that is taken frees the pipeline in the same cycle.
`include "assert_macros.svh"
module multi_shape_lfo #(
    parameter int PHASE_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Sample-tick items carrying the random draws.
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic signed [mslfo_pkg::SAMPLE_W-1:0]     i_draw_target,
    input  logic signed [mslfo_pkg::SAMPLE_W-1:0]     i_draw_walk,
    // Oscillator samples.
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic signed [mslfo_pkg::SAMPLE_W-1:0]     o_lfo_value,
    output logic                                      o_cycle_wrapped,
    // Register writes.
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [mslfo_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [mslfo_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    logic [mslfo_pkg::STEP_W-1:0] phase_step;
    mslfo_pkg::t_wave             wave_select;
    logic                         in_fire;
    logic                         s1_valid;
    logic                         s1_to_out;
    logic [PHASE_BITS-1:0]        s1_phase;
    mslfo_pkg::t_tick             s1_tick;

    // The first stage moves on when the result register is empty or being
    // taken; the input is ready whenever the first stage will be free.
    assign s1_to_out  = s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !s1_valid || s1_to_out;
    assign in_fire    = i_in_valid && o_in_ready;

    mslfo_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_phase_step  (phase_step),
        .o_wave_select (wave_select)
    );

    mslfo_state #(
        .PHASE_BITS (PHASE_BITS)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_fire),
        .i_drain       (s1_to_out),
        .i_phase_step  (phase_step),
        .i_draw_target (i_draw_target),
        .i_draw_walk   (i_draw_walk),
        .o_s1_valid    (s1_valid),
        .o_s1_phase    (s1_phase),
        .o_s1_tick     (s1_tick)
    );

    mslfo_shape #(
        .PHASE_BITS (PHASE_BITS)
    ) u_shape (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (s1_to_out),
        .i_out_ready     (i_out_ready),
        .i_wave_select   (wave_select),
        .i_phase         (s1_phase),
        .i_tick          (s1_tick),
        .o_out_valid     (o_out_valid),
        .o_lfo_value     (o_lfo_value),
        .o_cycle_wrapped (o_cycle_wrapped)
    );

    // A full pipeline with a taken result must keep accepting.
    `MSL_ASSERT(a_full_rate_when_drained, i_clk, i_rst_n, (o_out_valid && i_out_ready) |-> o_in_ready)
    // A stalled result register holds back the first stage.
    `MSL_ASSERT_NEVER(a_no_overwrite_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready && s1_to_out)

endmodule

// ===== sim/multi_shape_lfo_tb.sv =====
// Self-checking testbench of the multi-shape LFO: directed and random items against a predictor.
`timescale 1ns / 100ps

module multi_shape_lfo_tb;

    localparam int SAMPLE_W   = mslfo_pkg::SAMPLE_W;
    localparam int STEP_W     = mslfo_pkg::STEP_W;
    localparam int CFG_IDX_W  = mslfo_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mslfo_pkg::CFG_DATA_W;

    // Register indexes that no register answers to.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST         = 8'hFF;

    // Two register stages inside the block, and spare cycles to settle after the last result.
    localparam int PIPE_DEPTH     = 2;
    localparam int SETTLE_CYCLES  = 8;
    // The longest receiver hold-off used while the sender keeps offering items.
    localparam int RX_HOLD_CYCLES = 300;
    // Longest quiet stretch in a correct run is the hold-off plus a sender gap and
    // the pipeline, so a stretch past the watchdog limit with no transfer means a hang.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 20;
    localparam int RANDOM_PHASES  = 30;
    localparam int PHASE_TICKS    = 58;

    // One turn of the phase accumulator, and the shift from phase units to Q1.15.
    localparam longint ONE_TURN    = 64'sd16777216;
    localparam int     TURN_TO_Q15 = 9;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       wrapped;
    } t_lfo_sample;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_MOSTLY = 2'd3
    } t_rx_pattern;

    // How the walk draws lean, so that the walk level reaches both rails.
    typedef enum logic [1:0] {
        DRAW_UNIFORM = 2'd0,
        DRAW_RISE    = 2'd1,
        DRAW_FALL    = 2'd2
    } t_draw_bias;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_ready;
    logic signed [SAMPLE_W-1:0]  i_draw_target = '0;
    logic signed [SAMPLE_W-1:0]  i_draw_walk   = '0;
    logic                        o_out_valid;
    logic                        i_out_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_lfo_value;
    logic                        o_cycle_wrapped;
    logic                        i_cfg_valid   = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data    = '0;

    multi_shape_lfo DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_draw_target  (i_draw_target),
        .i_draw_walk    (i_draw_walk),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_lfo_value    (o_lfo_value),
        .o_cycle_wrapped(o_cycle_wrapped),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the oscillator: registers and running state.
    logic [STEP_W-1:0]          cfg_step;
    mslfo_pkg::t_wave           cfg_wave;
    logic [STEP_W-1:0]          osc_phase;
    logic signed [SAMPLE_W-1:0] osc_held;
    logic signed [SAMPLE_W-1:0] osc_target;
    logic signed [SAMPLE_W-1:0] osc_walk;

    // Samples the block still owes us, oldest first.
    t_lfo_sample pending_samples[$];

    int          mismatches    = 0;
    int          ticks_sent    = 0;
    int          samples_taken = 0;
    int          wraps_seen    = 0;
    int          settings_used = 0;
    int          idle_cycles   = 0;
    t_draw_bias  draw_bias     = DRAW_UNIFORM;

    // Receiver controls; only the initial block writes these.
    t_rx_pattern rx_mode       = RX_ALWAYS;
    int          hold_requests = 0;
    // Receiver's own bookkeeping.
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          rx_tick       = 0;

    t_lfo_sample got_sample;
    t_lfo_sample want_sample;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic signed [SAMPLE_W-1:0] clamp_q15(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Sine from the top ten phase bits: a quadrant is folded onto a Q30 angle
    // and fed through the odd polynomial with truncating Q30 products.
    function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [STEP_W-1:0] ph);
        logic [9:0]                 idx;
        logic [1:0]                 quad;
        longint unsigned            frac;
        longint unsigned            ang;
        longint unsigned            ang_sq;
        longint unsigned            acc;
        longint unsigned            prod;
        logic signed [SAMPLE_W-1:0] mag;
        idx    = ph[STEP_W-1 -: 10];
        quad   = idx[9:8];
        frac   = 64'(idx[7:0]) << 22;
        ang    = quad[0] ? ((64'd1 << 30) - frac) : frac;
        ang_sq = (ang * ang) >> 30;
        acc    = mslfo_pkg::SC9;
        acc    = mslfo_pkg::SC7 - ((ang_sq * acc) >> 30);
        acc    = mslfo_pkg::SC5 - ((ang_sq * acc) >> 30);
        acc    = mslfo_pkg::SC3 - ((ang_sq * acc) >> 30);
        acc    = mslfo_pkg::SC1 - ((ang_sq * acc) >> 30);
        prod   = (ang * acc) >> 30;
        prod   = (prod + 64'd16384) >> 15;
        if (prod > 64'd32767) begin
            prod = 64'd32767;
        end
        mag = 16'(prod);
        return quad[1] ? -mag : mag;
    endfunction

    // Advances the shadow oscillator by one tick and returns the sample it gives.
    function automatic t_lfo_sample predict_tick(input logic signed [SAMPLE_W-1:0] target_draw,
                                                 input logic signed [SAMPLE_W-1:0] walk_draw);
        t_lfo_sample       res;
        logic [STEP_W:0]   sum;
        longint            pos;
        longint            delta;
        longint            span;
        res = '0;
        // A zero step freezes everything and outputs silence.
        if (cfg_step != '0) begin
            sum = {1'b0, osc_phase} + {1'b0, cfg_step};
            if (sum[STEP_W]) begin
                // Wrap: shift the random pair and nudge the walk by a fifth of the draw.
                delta       = (longint'(walk_draw) * 6554 + 16384) >>> 15;
                res.wrapped = 1'b1;
                osc_held    = osc_target;
                osc_target  = target_draw;
                osc_walk    = clamp_q15(longint'(osc_walk) + delta);
            end
            osc_phase = sum[STEP_W-1:0];
            pos       = longint'(osc_phase);
            case (cfg_wave)
                mslfo_pkg::WAVE_SIN: begin
                    res.value = sine_at(osc_phase);
                end
                mslfo_pkg::WAVE_TRI: begin
                    span      = (pos < ONE_TURN / 2) ? (4 * pos - ONE_TURN)
                                                     : (3 * ONE_TURN - 4 * pos);
                    res.value = clamp_q15(span >>> TURN_TO_Q15);
                end
                mslfo_pkg::WAVE_SAW: begin
                    res.value = clamp_q15((2 * pos - ONE_TURN) >>> TURN_TO_Q15);
                end
                mslfo_pkg::WAVE_SQR: begin
                    res.value = (pos < ONE_TURN / 2) ? 16'sh7FFF : 16'sh8000;
                end
                mslfo_pkg::WAVE_HOLD: begin
                    res.value = osc_held;
                end
                mslfo_pkg::WAVE_SMOOTH: begin
                    span      = longint'(osc_target) - longint'(osc_held);
                    res.value = clamp_q15(longint'(osc_held) + ((span * pos) >>> STEP_W));
                end
                mslfo_pkg::WAVE_WALK: begin
                    res.value = osc_walk;
                end
                default: begin
                    // The zero select still lets phase and random state advance.
                    res.value = '0;
                end
            endcase
        end
        return res;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        // Unknown indexes are dropped; bits above a register's width are ignored.
        if (idx == mslfo_pkg::CFG_PHASE_STEP) begin
            cfg_step = data[STEP_W-1:0];
        end else if (idx == mslfo_pkg::CFG_WAVE_SELECT) begin
            cfg_wave = mslfo_pkg::t_wave'(data[2:0]);
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_q15(input t_draw_bias bias);
        int mag;
        mag = $urandom_range(8192, 32768);
        case ($urandom_range(0, 7))
            0: begin
                return 16'sh7FFF;
            end
            1: begin
                return 16'sh8000;
            end
            default: begin
                if (bias == DRAW_RISE) begin
                    return 16'(mag - 1);
                end else if (bias == DRAW_FALL) begin
                    return 16'(-mag);
                end
                return 16'($urandom());
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one tick item and holds it until the block takes it. Valid is left
    // high so that back-to-back items never lower and raise it in one step.
    task automatic send_tick(input logic signed [SAMPLE_W-1:0] target_draw,
                             input logic signed [SAMPLE_W-1:0] walk_draw);
        i_in_valid    <= 1'b1;
        i_draw_target <= target_draw;
        i_draw_walk   <= walk_draw;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_samples.push_back(predict_tick(target_draw, walk_draw));
        ticks_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Sends items in bursts of random length; with gaps on, quiet spells of
    // random length fall between the bursts.
    task automatic run_ticks(input int count, input bit with_gaps);
        int burst;
        burst = $urandom_range(1, 24);
        for (int n = 0; n < count; n++) begin
            send_tick(random_q15(DRAW_UNIFORM), random_q15(draw_bias));
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if (with_gaps) begin
                    pause_sender($urandom_range(1, 10));
                end
            end
        end
    endtask

    // Stops offering items and waits until every owed sample has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    // Writes both registers, the wave select with random junk above its three
    // bits, optionally preceded by a write to an index that does not exist.
    task automatic set_config(input logic [STEP_W-1:0] step, input mslfo_pkg::t_wave wave,
                              input bit stray_write);
        if (stray_write) begin
            write_reg(CFG_IDX_W'($urandom_range(int'(CFG_IDX_FIRST_UNUSED), int'(CFG_IDX_LAST))),
                      CFG_DATA_W'($urandom()));
        end
        write_reg(mslfo_pkg::CFG_PHASE_STEP, step);
        write_reg(mslfo_pkg::CFG_WAVE_SELECT, {21'($urandom()), wave});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // A hold-off request from the stimulus forces a long stall; otherwise
    // ready follows the current pattern.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_seen != hold_requests) begin
            hold_seen   <= hold_requests;
            hold_left   <= RX_HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= (rx_tick % 5 == 0);
                default:   i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatches < MAX_PRINTED) begin
            $display("mismatch on sample %0d: %s, expected %0d, got %0d",
                     samples_taken, what, want, got);
        end
        mismatches++;
    endtask

    // Every sample taken from the block is matched against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_sample.value   = o_lfo_value;
            got_sample.wrapped = o_cycle_wrapped;
            if (pending_samples.size() == 0) begin
                report_mismatch("sample with nothing owed", 0, int'(got_sample.value));
            end else begin
                want_sample = pending_samples.pop_front();
                if (got_sample.value !== want_sample.value) begin
                    report_mismatch("lfo value", int'(want_sample.value),
                                    int'(got_sample.value));
                end
                if (got_sample.wrapped !== want_sample.wrapped) begin
                    report_mismatch("wrap flag", int'(want_sample.wrapped),
                                    int'(got_sample.wrapped));
                end
            end
            samples_taken++;
            if (o_cycle_wrapped === 1'b1) begin
                wraps_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("no transfer for %0d cycles, giving up", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the step is zero: silence, no wrap, draws ignored.
    task automatic test_zero_step_after_reset();
        rx_mode <= RX_ALWAYS;
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000);
        wait_idle();
    endtask

    // The largest step wraps on nearly every tick; the first tick from zero
    // phase does not. The extreme draws go straight into the target and nudge the walk.
    task automatic test_full_step_sine();
        set_config(24'hFFFFFF, mslfo_pkg::WAVE_SIN, 1'b0);
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000);
        send_tick(16'sh7FFF, 16'sh7FFF);
        wait_idle();
    endtask

    // A quarter-turn step moves the phase across a quadrant boundary on every
    // tick. Each remaining shape gets two ticks.
    task automatic test_each_shape();
        for (int w = int'(mslfo_pkg::WAVE_TRI); w <= int'(mslfo_pkg::WAVE_ZERO); w++) begin
            set_config(24'h400000, mslfo_pkg::t_wave'(w), 1'b0);
            send_tick(16'sh7FFF, 16'sh8000);
            send_tick(16'sh8000, 16'sh7FFF);
            wait_idle();
        end
    endtask

    // Writes to missing indexes change nothing, junk above the select is dropped,
    // and a one-unit step never wraps so the draws are ignored.
    task automatic test_register_edges();
        write_reg(CFG_IDX_FIRST_UNUSED, 24'hFFFFFF);
        write_reg(CFG_IDX_LAST, 24'h000000);
        write_reg(mslfo_pkg::CFG_WAVE_SELECT, {21'h1FFFFF, mslfo_pkg::WAVE_SAW});
        write_reg(mslfo_pkg::CFG_PHASE_STEP, 24'h000001);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // both stages fill and the input stalls; then the sender waits for all
    // results before going on.
    task automatic test_output_stall();
        set_config(24'h0A3D71, mslfo_pkg::WAVE_SMOOTH, 1'b0);
        rx_mode       <= RX_ALWAYS;
        hold_requests <= hold_requests + 1;
        run_ticks(40, 1'b0);
        wait_idle();
    endtask

    // Random phases: a fresh register setting, stall pattern and draw lean each
    // time, then a run of items with random content.
    task automatic test_random_phases();
        logic [STEP_W-1:0] step;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0: step = '0;
                1: step = 24'hFFFFFF;
                2: step = STEP_W'($urandom_range(1, 4096));
                3: step = 24'h800000;
                4: step = STEP_W'($urandom_range(24'h100000, 24'hFFFFFF));
                5: step = STEP_W'($urandom_range(24'h010000, 24'h400000));
                6: step = STEP_W'($urandom_range(24'hF00000, 24'hFFFFFF));
                default: step = STEP_W'($urandom());
            endcase
            draw_bias = t_draw_bias'($urandom_range(0, 2));
            rx_mode  <= t_rx_pattern'($urandom_range(0, 3));
            set_config(step, mslfo_pkg::t_wave'($urandom_range(0, 7)),
                       $urandom_range(0, 3) == 0);
            run_ticks(PHASE_TICKS, $urandom_range(0, 3) != 0);
            wait_idle();
        end
    endtask

    initial begin
        cfg_step   = '0;
        cfg_wave   = mslfo_pkg::WAVE_SIN;
        osc_phase  = '0;
        osc_held   = '0;
        osc_target = '0;
        osc_walk   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_step_after_reset();
        test_full_step_sine();
        test_each_shape();
        test_register_edges();
        test_output_stall();
        test_random_phases();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d ticks over %0d register settings, all eight shape selects,",
                 ticks_sent, settings_used);
        $display("stray register writes, output stalls and %0d phase wraps; %0d mismatches.",
                 wraps_seen, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
